// File: hdl/dq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the double-ended queue
// no dependencies

package dq_pkg;

    localparam int VALUE_W   = 32;
    localparam int ENTRIES_W = 7;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ_FWD   = 3'd4,
        OP_READ_BWD   = 3'd5,
        OP_COUNT      = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_OUT,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic    wr_front;
        logic    wr_back;
        logic    pop_front;
        logic    pop_back;
        logic    scan_fwd;
        logic    scan_bwd;
        logic    scan_step;
        logic    out_load;
        logic    out_mem;
        status_t out_status;
        logic    out_last;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

// File: hdl/dq_req_if.sv
`timescale 1ns / 1ps
// request channel: op code and value to push
// depends on dq_pkg

interface dq_req_if;
    logic                              valid;
    logic                              ready;
    logic        [dq_pkg::OP_W-1:0]    op;
    logic signed [dq_pkg::VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

// File: hdl/dq_res_if.sv
`timescale 1ns / 1ps
// result channel: popped or read value, entry count, status, last flag
// depends on dq_pkg

interface dq_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [dq_pkg::VALUE_W-1:0]   value_res;
    logic        [dq_pkg::ENTRIES_W-1:0] entries;
    logic        [dq_pkg::STATUS_W-1:0]  status;
    logic                                last;

    modport source (output valid, output value_res, output entries, output status,
                    output last, input ready);
    modport sink   (input valid, input value_res, input entries, input status,
                    input last, output ready);
endinterface

// File: hdl/dq_ctrl.sv
`timescale 1ns / 1ps
// controller state machine for the double-ended queue
// depends on dq_pkg; drives commands into dq_dp

module dq_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic [dq_pkg::OP_W-1:0]   req_op,
    output logic                      req_ready,
    input  dq_pkg::sts_t              sts,
    output dq_pkg::cmd_t              cmd
);

    dq_pkg::state_t state_reg;
    dq_pkg::state_t state_next;
    logic           accept;

    assign req_ready = (state_reg == dq_pkg::S_IDLE) && sts.out_free;
    assign accept    = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (dq_pkg::op_t'(req_op))
                        dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK:
                        begin
                            if (!sts.empty)
                            begin
                                state_next = dq_pkg::S_POP_OUT;
                            end
                        end
                        dq_pkg::OP_READ_FWD, dq_pkg::OP_READ_BWD:
                        begin
                            if (!sts.empty)
                            begin
                                state_next = dq_pkg::S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = dq_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            dq_pkg::S_POP_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = dq_pkg::S_IDLE;
                end
            end
            dq_pkg::S_SCAN:
            begin
                if (sts.out_free && sts.scan_last)
                begin
                    state_next = dq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dq_pkg::S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd            = '0;
        cmd.out_status = dq_pkg::STS_OK;
        case (state_reg)
            dq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (dq_pkg::op_t'(req_op))
                        dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK:
                        begin
                            if (sts.full)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = dq_pkg::STS_FULL;
                                cmd.out_last   = 1'b1;
                            end
                            else if (dq_pkg::op_t'(req_op) == dq_pkg::OP_PUSH_FRONT)
                            begin
                                cmd.wr_front = 1'b1;
                            end
                            else
                            begin
                                cmd.wr_back = 1'b1;
                            end
                        end
                        dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK,
                        dq_pkg::OP_READ_FWD, dq_pkg::OP_READ_BWD:
                        begin
                            if (sts.empty)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = dq_pkg::STS_EMPTY;
                                cmd.out_last   = 1'b1;
                            end
                            else
                            begin
                                cmd.pop_front = (dq_pkg::op_t'(req_op) == dq_pkg::OP_POP_FRONT);
                                cmd.pop_back  = (dq_pkg::op_t'(req_op) == dq_pkg::OP_POP_BACK);
                                cmd.scan_fwd  = (dq_pkg::op_t'(req_op) == dq_pkg::OP_READ_FWD);
                                cmd.scan_bwd  = (dq_pkg::op_t'(req_op) == dq_pkg::OP_READ_BWD);
                            end
                        end
                        dq_pkg::OP_COUNT:
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_last = 1'b1;
                        end
                        default:
                        begin
                            cmd.out_load = 1'b0;
                        end
                    endcase
                end
            end
            dq_pkg::S_POP_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_mem  = 1'b1;
                    cmd.out_last = 1'b1;
                end
            end
            dq_pkg::S_SCAN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_mem   = 1'b1;
                    cmd.out_last  = sts.scan_last;
                    cmd.scan_step = !sts.scan_last;
                end
            end
            default:
            begin
                cmd.out_load = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/dq_dp.sv
`timescale 1ns / 1ps
// datapath: ring buffer memory, front index, entry count, scan pointer, result register
// depends on dq_pkg and dq_res_if; commanded by dq_ctrl

module dq_dp #(
    parameter int DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [dq_pkg::VALUE_W-1:0] push_value,
    input  dq_pkg::cmd_t                      cmd,
    output dq_pkg::sts_t                      sts,
    dq_res_if.source                          res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [dq_pkg::VALUE_W-1:0] mem [DEPTH];

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW-1:0] rem_reg, rem_next;
    logic          bwd_reg, bwd_next;
    logic          ov_reg, ov_next;

    logic [dq_pkg::VALUE_W-1:0]   rd_data_reg;
    logic [dq_pkg::VALUE_W-1:0]   ovalue_reg;
    logic [dq_pkg::ENTRIES_W-1:0] oentries_reg;
    dq_pkg::status_t              ostatus_reg;
    logic                         olast_reg;

    logic [AW-1:0] cnt_lo;
    logic [AW-1:0] back_pos;
    logic [AW-1:0] back_wr;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] rp_step;
    logic [AW-1:0] rd_addr;
    logic          rd_en;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(DEPTH))
        begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
    endfunction

    assign cnt_lo    = count_reg[AW-1:0];
    assign back_pos  = ring_add(front_reg, cnt_lo - AW'(1));
    assign back_wr   = ring_add(front_reg, cnt_lo);
    assign front_dec = ring_dec(front_reg);
    assign rp_step   = bwd_reg ? ring_dec(rp_reg) : ring_inc(rp_reg);

    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == CW'(DEPTH));
    assign sts.scan_last = (rem_reg == '0);
    assign sts.out_free  = !ov_reg || res.ready;

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        rp_next    = rp_reg;
        rem_next   = rem_reg;
        bwd_next   = bwd_reg;
        rd_addr    = front_reg;
        rd_en      = 1'b0;
        if (cmd.wr_front)
        begin
            front_next = front_dec;
            count_next = count_reg + CW'(1);
        end
        if (cmd.wr_back)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.pop_front)
        begin
            front_next = ring_inc(front_reg);
            count_next = count_reg - CW'(1);
            rd_addr    = front_reg;
            rd_en      = 1'b1;
        end
        if (cmd.pop_back)
        begin
            count_next = count_reg - CW'(1);
            rd_addr    = back_pos;
            rd_en      = 1'b1;
        end
        if (cmd.scan_fwd || cmd.scan_bwd)
        begin
            rp_next  = cmd.scan_bwd ? back_pos : front_reg;
            rem_next = cnt_lo - AW'(1);
            bwd_next = cmd.scan_bwd;
            rd_addr  = cmd.scan_bwd ? back_pos : front_reg;
            rd_en    = 1'b1;
        end
        if (cmd.scan_step)
        begin
            rp_next  = rp_step;
            rem_next = rem_reg - AW'(1);
            rd_addr  = rp_step;
            rd_en    = 1'b1;
        end
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (cmd.out_load)
        begin
            ov_next = 1'b1;
        end
        else if (res.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            rp_reg    <= '0;
            rem_reg   <= '0;
            bwd_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            rp_reg    <= rp_next;
            rem_reg   <= rem_next;
            bwd_reg   <= bwd_next;
            ov_reg    <= ov_next;
        end
    end

    // ring buffer storage
    always_ff @(posedge clk)
    begin
        if (cmd.wr_front)
        begin
            mem[front_dec] <= push_value;
        end
        else if (cmd.wr_back)
        begin
            mem[back_wr] <= push_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            ovalue_reg   <= cmd.out_mem ? rd_data_reg : '0;
            oentries_reg <= dq_pkg::ENTRIES_W'(count_reg);
            ostatus_reg  <= cmd.out_status;
            olast_reg    <= cmd.out_last;
        end
    end

    assign res.valid     = ov_reg;
    assign res.value_res = ovalue_reg;
    assign res.entries   = oentries_reg;
    assign res.status    = ostatus_reg;
    assign res.last      = olast_reg;

endmodule

// File: hdl/double_ended_queue.sv
`timescale 1ns / 1ps
// top level of the double-ended queue: controller plus ring buffer datapath
// depends on dq_pkg, dq_req_if, dq_res_if, dq_ctrl, dq_dp
//
//  channel  dir  payload                              transaction per
//  req      in   op, value                            request
//  res      out  value_res, entries, status, last     result
//
// push: no result; count, full push or empty pop/readout: result in the cycle after acceptance
// pop: the registered memory read port captures the value, then the result register loads it
// readout of n entries: read register then result register, one entry per cycle unless res stalls
// req.ready is low while a pop or readout is in flight and while a held result blocks the register
// reset clears front index, count and result valid; storage is not cleared
// a stall on res holds the result register and pauses the readout

module double_ended_queue #(
    parameter int DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    dq_req_if.sink    req,
    dq_res_if.source  res
);

    dq_pkg::cmd_t cmd;
    dq_pkg::sts_t sts;
    logic         ready_w;

    assign req.ready = ready_w;

    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_ready (ready_w),
        .sts       (sts),
        .cmd       (cmd)
    );

    dq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_value (req.value),
        .cmd        (cmd),
        .sts        (sts),
        .res        (res)
    );

endmodule

// File: hdl/dq_checker.sv
`timescale 1ns / 1ps
// port-level checks for the double-ended queue, bound to the top level
// depends on dq_pkg and double_ended_queue

module dq_checker #(
    parameter int DEPTH = 64
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic [dq_pkg::OP_W-1:0]        req_op,
    input logic                           res_valid,
    input logic                           res_ready,
    input logic [dq_pkg::ENTRIES_W-1:0]   res_entries,
    input logic [dq_pkg::STATUS_W-1:0]    res_status,
    input logic                           res_last
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_count_next: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_op == dq_pkg::OP_COUNT) |=> res_valid && res_last)
        else $error("count transaction gave no result in the next cycle");

    a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_last |-> !req_ready)
        else $error("request taken during a readout");

    a_status_entries: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == dq_pkg::STS_EMPTY || res_status == dq_pkg::STS_FULL)
        |-> res_last && ((res_status == dq_pkg::STS_EMPTY) ? (res_entries == '0)
                         : (res_entries == dq_pkg::ENTRIES_W'(DEPTH))))
        else $error("error status with wrong entry count");

endmodule

bind double_ended_queue dq_checker #(
    .DEPTH (DEPTH)
) u_dq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_op      (req.op),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_entries (res.entries),
    .res_status  (res.status),
    .res_last    (res.last)
);

// File: tb/sv/double_ended_queue_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for double_ended_queue: drives requests, predicts results with a
// shadow ring buffer and checks every result transaction in order
// depends on dq_pkg, dq_req_if, dq_res_if and the double_ended_queue rtl

module double_ended_queue_tb;

    localparam int DEPTH = 64;
    localparam logic [dq_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int IDLE_PCT = 8;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic signed [dq_pkg::VALUE_W-1:0]   value_res;
        logic        [dq_pkg::ENTRIES_W-1:0] entries;
        dq_pkg::status_t                     status;
        logic                                last;
    } deque_result_t;

    logic clk;
    logic rst_n;

    dq_req_if req_if ();
    dq_res_if res_if ();

    double_ended_queue #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .res   (res_if.source)
    );

    logic signed [dq_pkg::VALUE_W-1:0] shadow_slots [DEPTH];
    int                                shadow_front;
    int                                shadow_count;
    deque_result_t                     owed_results [$];
    deque_result_t                     oldest_owed;
    int                                error_count;
    bit                                no_stall;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic void owe(input logic signed [dq_pkg::VALUE_W-1:0] v,
                                input dq_pkg::status_t st,
                                input logic lst);
        deque_result_t r;
        r.value_res = v;
        r.entries   = shadow_count[dq_pkg::ENTRIES_W-1:0];
        r.status    = st;
        r.last      = lst;
        owed_results.push_back(r);
    endfunction

    function automatic void shadow_deque_apply(input logic [dq_pkg::OP_W-1:0] code,
                                               input logic signed [dq_pkg::VALUE_W-1:0] v);
        int k;
        int off;
        logic signed [dq_pkg::VALUE_W-1:0] x;
        case (code)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK:
            begin
                if (shadow_count >= DEPTH)
                begin
                    owe('0, dq_pkg::STS_FULL, 1'b1);
                end
                else
                begin
                    if (code == dq_pkg::OP_PUSH_FRONT)
                    begin
                        shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                        shadow_slots[shadow_front] = v;
                    end
                    else
                    begin
                        shadow_slots[(shadow_front + shadow_count) % DEPTH] = v;
                    end
                    shadow_count++;
                end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK:
            begin
                if (shadow_count == 0)
                begin
                    owe('0, dq_pkg::STS_EMPTY, 1'b1);
                end
                else
                begin
                    if (code == dq_pkg::OP_POP_FRONT)
                    begin
                        x = shadow_slots[shadow_front];
                        shadow_front = (shadow_front + 1) % DEPTH;
                    end
                    else
                    begin
                        x = shadow_slots[(shadow_front + shadow_count - 1) % DEPTH];
                    end
                    shadow_count--;
                    owe(x, dq_pkg::STS_OK, 1'b1);
                end
            end
            dq_pkg::OP_READ_FWD, dq_pkg::OP_READ_BWD:
            begin
                if (shadow_count == 0)
                begin
                    owe('0, dq_pkg::STS_EMPTY, 1'b1);
                end
                else
                begin
                    for (k = 0; k < shadow_count; k++)
                    begin
                        off = (code == dq_pkg::OP_READ_FWD) ? k : shadow_count - 1 - k;
                        owe(shadow_slots[(shadow_front + off) % DEPTH], dq_pkg::STS_OK,
                            k + 1 == shadow_count);
                    end
                end
            end
            dq_pkg::OP_COUNT:
            begin
                owe('0, dq_pkg::STS_OK, 1'b1);
            end
            default:
            begin
            end
        endcase
    endfunction

    // called and returns at a falling edge
    task automatic send_request(input logic [dq_pkg::OP_W-1:0] code,
                                input logic signed [dq_pkg::VALUE_W-1:0] v);
        while (!no_stall && $urandom_range(99) < IDLE_PCT)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.op    <= code;
        req_if.value <= v;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
        shadow_deque_apply(code, v);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            res_if.ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (owed_results.size() == 0)
            begin
                report_mismatch("unexpected result value_res", res_if.value_res, 0);
            end
            else
            begin
                oldest_owed = owed_results.pop_front();
                if (res_if.value_res !== oldest_owed.value_res)
                begin
                    report_mismatch("value_res", res_if.value_res, oldest_owed.value_res);
                end
                if (res_if.entries !== oldest_owed.entries)
                begin
                    report_mismatch("entries", res_if.entries, oldest_owed.entries);
                end
                if (res_if.status !== oldest_owed.status)
                begin
                    report_mismatch("status", res_if.status, oldest_owed.status);
                end
                if (res_if.last !== oldest_owed.last)
                begin
                    report_mismatch("last", res_if.last, oldest_owed.last);
                end
            end
        end
    end

    task automatic test_empty_deque();
        send_request(dq_pkg::OP_POP_FRONT, $urandom);
        send_request(dq_pkg::OP_POP_BACK, $urandom);
        send_request(dq_pkg::OP_READ_FWD, $urandom);
        send_request(dq_pkg::OP_READ_BWD, $urandom);
        send_request(dq_pkg::OP_COUNT, $urandom);
        send_request(OP_UNUSED, $urandom);
        send_request(dq_pkg::OP_COUNT, 32'sd0);
    endtask

    task automatic test_value_extremes();
        send_request(dq_pkg::OP_PUSH_BACK, 32'sh7fff_ffff);
        send_request(dq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
        send_request(dq_pkg::OP_PUSH_BACK, 32'sd0);
        send_request(dq_pkg::OP_PUSH_FRONT, -32'sd1);
        send_request(dq_pkg::OP_PUSH_BACK, 32'sh5555_5555);
        send_request(dq_pkg::OP_PUSH_FRONT, 32'shaaaa_aaaa);
        send_request(OP_UNUSED, 32'sh1234_5678);
        send_request(dq_pkg::OP_COUNT, 32'sd0);
        send_request(dq_pkg::OP_READ_FWD, 32'sd0);
        send_request(dq_pkg::OP_READ_BWD, 32'sd0);
        send_request(dq_pkg::OP_POP_FRONT, 32'sd0);
        send_request(dq_pkg::OP_POP_BACK, 32'sd0);
        send_request(dq_pkg::OP_POP_FRONT, 32'sd0);
        send_request(dq_pkg::OP_POP_BACK, 32'sd0);
        send_request(dq_pkg::OP_READ_BWD, 32'sd0);
        send_request(dq_pkg::OP_POP_FRONT, 32'sd0);
        send_request(dq_pkg::OP_POP_BACK, 32'sd0);
        send_request(dq_pkg::OP_READ_FWD, 32'sd0);
    endtask

    task automatic test_fill_and_overflow();
        int i;
        no_stall = 1'b1;
        for (i = 0; i < DEPTH; i++)
        begin
            send_request($urandom_range(1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK,
                         $urandom);
        end
        send_request(dq_pkg::OP_PUSH_FRONT, $urandom);
        send_request(dq_pkg::OP_PUSH_BACK, $urandom);
        send_request(dq_pkg::OP_COUNT, 32'sd0);
        no_stall = 1'b0;
        send_request(dq_pkg::OP_READ_FWD, 32'sd0);
        send_request(dq_pkg::OP_READ_BWD, 32'sd0);
        for (i = 0; i < DEPTH; i++)
        begin
            send_request($urandom_range(1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK,
                         $urandom);
        end
        send_request(dq_pkg::OP_COUNT, 32'sd0);
    endtask

    task automatic test_random_traffic(input int n_items);
        int i;
        int r;
        int push_pct;
        logic [dq_pkg::OP_W-1:0] code;
        push_pct = 80;
        for (i = 0; i < n_items; i++)
        begin
            if (i % 45 == 44)
            begin
                push_pct = (push_pct > 50) ? 20 : 80;
            end
            r = $urandom_range(99);
            if (r < push_pct)
            begin
                code = $urandom_range(1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 70)
                begin
                    code = $urandom_range(1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK;
                end
                else if (r < 85)
                begin
                    code = $urandom_range(1) ? dq_pkg::OP_READ_FWD : dq_pkg::OP_READ_BWD;
                end
                else if (r < 95)
                begin
                    code = dq_pkg::OP_COUNT;
                end
                else
                begin
                    code = OP_UNUSED;
                end
            end
            send_request(code, $urandom);
        end
    endtask

    initial
    begin
        int wait_cycles;
        rst_n         = 1'b0;
        req_if.valid  = 1'b0;
        req_if.op     = dq_pkg::OP_COUNT;
        req_if.value  = '0;
        res_if.ready  = 1'b0;
        shadow_front  = 0;
        shadow_count  = 0;
        error_count   = 0;
        no_stall      = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_deque();
        test_value_extremes();
        test_fill_and_overflow();
        test_random_traffic(250);
        req_if.valid <= 1'b0;

        wait_cycles = 0;
        while (owed_results.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && owed_results.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            if (owed_results.size() != 0)
            begin
                report_mismatch("results never delivered", 0, owed_results.size());
            end
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/dq_pkg.sv
hdl/dq_req_if.sv
hdl/dq_res_if.sv
hdl/dq_ctrl.sv
hdl/dq_dp.sv
hdl/double_ended_queue.sv
hdl/dq_checker.sv
tb/sv/double_ended_queue_tb.sv
